// ===== rtl/core/mnc_pkg.sv =====
// mnc_pkg: shared types, constants and functions of the morton neighbour cell block
// no dependencies; imported by every module under rtl/core
package mnc_pkg;

  localparam int AXIS_BITS   = 21;
  localparam int CODE_W      = 3 * AXIS_BITS;
  localparam int CELLS_W     = AXIS_BITS + 1;
  localparam int IDX_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = CELLS_W;
  localparam int IN_TDATA_W  = ((CODE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CODE_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - CODE_W - IDX_W;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // reset values of the registers
  localparam logic               REACH_RST = 1'b1;
  localparam logic [CELLS_W-1:0] CELLS_RST = CELLS_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REACH   = 2'd0,
    CFG_CELLS_X = 2'd1,
    CFG_CELLS_Y = 2'd2,
    CFG_CELLS_Z = 2'd3
  } cfg_reg_t;

  // per-axis offset step codes
  localparam logic [1:0] OFS_MINUS = 2'd0;
  localparam logic [1:0] OFS_ZERO  = 2'd1;
  localparam logic [1:0] OFS_PLUS  = 2'd2;

  // one classified item: coordinates, in-grid flags for offsets -1, 0, +1 and the reach bit
  typedef struct packed {
    logic [AXIS_BITS-1:0] kx;
    logic [AXIS_BITS-1:0] ky;
    logic [AXIS_BITS-1:0] kz;
    logic [2:0]           vx;
    logic [2:0]           vy;
    logic [2:0]           vz;
    logic                 reach;
  } mnc_entry_t;

  function automatic logic [AXIS_BITS-1:0] morton_split(input logic [CODE_W-1:0] code,
                                                        input int axis);
    logic [AXIS_BITS-1:0] v;
    v = '0;
    for (int i = 0; i < AXIS_BITS; i++) begin
      v[i] = code[3*i + axis];
    end
    return v;
  endfunction

  function automatic logic [CODE_W-1:0] morton_join(input logic [AXIS_BITS-1:0] x,
                                                    input logic [AXIS_BITS-1:0] y,
                                                    input logic [AXIS_BITS-1:0] z);
    logic [CODE_W-1:0] c;
    c = '0;
    for (int i = 0; i < AXIS_BITS; i++) begin
      c[3*i]     = x[i];
      c[3*i + 1] = y[i];
      c[3*i + 2] = z[i];
    end
    return c;
  endfunction

  // bit 0: k-1 inside, bit 1: k inside, bit 2: k+1 inside
  function automatic logic [2:0] axis_flags(input logic [AXIS_BITS-1:0] k,
                                            input logic [CELLS_W-1:0]   count);
    logic [CELLS_W-1:0] k_w;
    logic [2:0]         f;
    k_w  = {1'b0, k};
    f[0] = (k != '0) && ((k_w - CELLS_W'(1)) < count);
    f[1] = k_w < count;
    f[2] = (k != '1) && ((k_w + CELLS_W'(1)) < count);
    return f;
  endfunction

  function automatic logic [AXIS_BITS-1:0] step_coord(input logic [AXIS_BITS-1:0] k,
                                                      input logic [1:0]           sel);
    logic [AXIS_BITS-1:0] v;
    case (sel)
      OFS_MINUS: v = k - AXIS_BITS'(1);
      OFS_PLUS:  v = k + AXIS_BITS'(1);
      default:   v = k;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/mnc_front.sv =====
// mnc_front: register file and input classifier of the neighbour cell block
// depends on mnc_pkg
module mnc_front import mnc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  q_full,
  output logic                  push,
  output mnc_entry_t            entry
);

  logic               reach_r;
  logic [CELLS_W-1:0] cells_x_r;
  logic [CELLS_W-1:0] cells_y_r;
  logic [CELLS_W-1:0] cells_z_r;
  logic [CODE_W-1:0]  code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r   <= REACH_RST;
      cells_x_r <= CELLS_RST;
      cells_y_r <= CELLS_RST;
      cells_z_r <= CELLS_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_REACH:   reach_r   <= cfg_wdata[0];
        CFG_CELLS_X: cells_x_r <= cfg_wdata;
        CFG_CELLS_Y: cells_y_r <= cfg_wdata;
        CFG_CELLS_Z: cells_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;
  assign code      = in_tdata[CODE_W-1:0];

  always_comb begin
    entry.kx    = morton_split(code, 0);
    entry.ky    = morton_split(code, 1);
    entry.kz    = morton_split(code, 2);
    entry.vx    = axis_flags(entry.kx, cells_x_r);
    entry.vy    = axis_flags(entry.ky, cells_y_r);
    entry.vz    = axis_flags(entry.kz, cells_z_r);
    entry.reach = reach_r;
  end

endmodule

// ===== rtl/core/mnc_queue.sv =====
// mnc_queue: short queue of classified items between front and back
// depends on mnc_pkg
module mnc_queue import mnc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  mnc_entry_t wr_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output mnc_entry_t head
);

  mnc_entry_t         slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;

  assign full       = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/mnc_back.sv =====
// mnc_back: offset walker and output register of the neighbour cell block
// depends on mnc_pkg
module mnc_back import mnc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  mnc_entry_t             head,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic [1:0]        cnt_x_r, cnt_y_r, cnt_z_r;
  logic [1:0]        cnt_x_nxt, cnt_y_nxt, cnt_z_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [1:0]        sel_x, sel_y, sel_z;
  logic              ok;
  logic              last;
  logic              load;
  logic [CODE_W-1:0] code;

  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_present_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;

  // reach 0 pins every axis to the zero offset
  assign sel_x = head.reach ? cnt_x_r : OFS_ZERO;
  assign sel_y = head.reach ? cnt_y_r : OFS_ZERO;
  assign sel_z = head.reach ? cnt_z_r : OFS_ZERO;

  assign ok   = head.vx[sel_x] && head.vy[sel_y] && head.vz[sel_z];
  assign last = !head.reach ||
                ((cnt_x_r == OFS_PLUS) && (cnt_y_r == OFS_PLUS) && (cnt_z_r == OFS_PLUS));
  assign code = ok ? morton_join(step_coord(head.kx, sel_x), step_coord(head.ky, sel_y),
                                 step_coord(head.kz, sel_z)) : '0;

  assign load = head_valid && (!out_valid_r || out_tready);
  assign pop  = load && last;

  always_comb begin
    cnt_x_nxt = cnt_x_r;
    cnt_y_nxt = cnt_y_r;
    cnt_z_nxt = cnt_z_r;
    idx_nxt   = idx_r;
    if (load) begin
      if (last) begin
        cnt_x_nxt = OFS_MINUS;
        cnt_y_nxt = OFS_MINUS;
        cnt_z_nxt = OFS_MINUS;
        idx_nxt   = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
        if (cnt_z_r != OFS_PLUS) begin
          cnt_z_nxt = cnt_z_r + 2'd1;
        end else begin
          cnt_z_nxt = OFS_MINUS;
          if (cnt_y_r != OFS_PLUS) begin
            cnt_y_nxt = cnt_y_r + 2'd1;
          end else begin
            cnt_y_nxt = OFS_MINUS;
            cnt_x_nxt = cnt_x_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_x_r     <= OFS_MINUS;
      cnt_y_r     <= OFS_MINUS;
      cnt_z_r     <= OFS_MINUS;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_x_r <= cnt_x_nxt;
      cnt_y_r <= cnt_y_nxt;
      cnt_z_r <= cnt_z_nxt;
      idx_r   <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_code_r    <= code;
      out_present_r <= ok;
      out_idx_r     <= idx_r;
      out_last_r    <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_idx_r, out_code_r};
  assign out_tuser  = out_present_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/morton_neighbour_cells.sv =====
// morton_neighbour_cells: 3d morton neighbour cell enumerator, top level
// path: an accepted item enters a queue slot; its words leave through the output register
// throughput: 27 words per item at reach 1, one word at reach 0, one word per cycle
//   while out_tready is high; the offset walker in the back half sets the item rate
// reset: synchronous active-low rst_n; reach = 1, cell counts = 10, queue empty
// depends on mnc_pkg, mnc_front, mnc_queue, mnc_back
module morton_neighbour_cells import mnc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // input words
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // cell_code [62:0], zero pad [63]
  // result words
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // neighbour_code [62:0], offset_index [67:63], pad
  output logic                   out_tuser,  // present
  output logic                   out_tlast   // last word of the run
);

  // front to queue
  mnc_entry_t entry;
  logic       push;
  logic       q_full;

  // queue to back
  mnc_entry_t head;
  logic       head_valid;
  logic       pop;

  // front decodes the cell code and does all bound compares up front,
  // so the back only selects flags and adds or subtracts one per axis
  mnc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .entry     (entry)
  );

  // two entries let the next item wait while the current run streams out
  mnc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_entry   (entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back walks the offsets of the queue head and pops it with the last word
  mnc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a cell outside the grid carries a zero code
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[CODE_W-1:0] == '0)
    else $error("absent neighbour with nonzero code");

  // a run never pauses inside the block once a word is taken
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("run stalled inside block");

  // offset index counts up by one within a run
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tdata[CODE_W+IDX_W-1:CODE_W] == $past(out_tdata[CODE_W+IDX_W-1:CODE_W]) + IDX_W'(1))
    else $error("offset index out of sequence");

  // a queue entry only leaves together with a last word
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_tvalid && out_tlast)
    else $error("queue popped without last word");

endmodule

// ===== bench/tb_morton_neighbour_cells.sv =====
// tb_morton_neighbour_cells: self-checking bench for the morton neighbour cell block,
// a scoreboard class predicts every neighbour word and random stalls hit both streams
// depends on mnc_pkg and the rtl top morton_neighbour_cells
module tb_morton_neighbour_cells;
  import mnc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // generous cycle limit
  localparam int CYCLE_LIMIT = 1000000;
  localparam longint AXIS_SPAN = 64'd1 << AXIS_BITS;
  localparam longint AXIS_MAX  = AXIS_SPAN - 1;

  // one expected neighbour word
  typedef struct {
    logic [CODE_W-1:0] code;
    logic              present;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } nbr_word_t;

  // neighbour predictor plus the queue of words still owed by the block
  class neighbour_board;
    logic              reach;
    logic [CELLS_W-1:0] cells_x, cells_y, cells_z;
    nbr_word_t         owed[$];
    int                errors;
    int                cells_seen;
    int                words_seen;

    function void reset_regs();
      reach   = 1'b1;
      cells_x = CELLS_W'(10);
      cells_y = CELLS_W'(10);
      cells_z = CELLS_W'(10);
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_REACH:   reach   = val[0];
        CFG_CELLS_X: cells_x = val[CELLS_W-1:0];
        CFG_CELLS_Y: cells_y = val[CELLS_W-1:0];
        CFG_CELLS_Z: cells_z = val[CELLS_W-1:0];
        default: ;
      endcase
    endfunction

    // interleave three axis coordinates, x in bit 0 of each triple
    function logic [CODE_W-1:0] pack_cell(longint x, longint y, longint z);
      logic [CODE_W-1:0] c;
      c = '0;
      for (int i = 0; i < AXIS_BITS; i++) begin
        c[3*i]     = x[i];
        c[3*i + 1] = y[i];
        c[3*i + 2] = z[i];
      end
      return c;
    endfunction

    // a neighbour coordinate must be in the grid and encodable
    function bit in_grid(longint c, logic [CELLS_W-1:0] count);
      return (c >= 0) && (c < longint'(count)) && (c < AXIS_SPAN);
    endfunction

    // walk the offset cube, x slowest and z fastest
    function void predict_run(logic [CODE_W-1:0] code);
      longint    k[3];
      longint    nx, ny, nz;
      int        r, total, n;
      nbr_word_t w;
      for (int a = 0; a < 3; a++) begin
        k[a] = 0;
        for (int i = 0; i < AXIS_BITS; i++) k[a][i] = code[3*i + a];
      end
      r = reach ? 1 : 0;
      total = (2*r + 1) * (2*r + 1) * (2*r + 1);
      n = 0;
      for (int dx = -r; dx <= r; dx++) begin
        for (int dy = -r; dy <= r; dy++) begin
          for (int dz = -r; dz <= r; dz++) begin
            nx = k[0] + dx;
            ny = k[1] + dy;
            nz = k[2] + dz;
            w.present = in_grid(nx, cells_x) && in_grid(ny, cells_y) && in_grid(nz, cells_z);
            w.code    = w.present ? pack_cell(nx, ny, nz) : '0;
            w.idx     = IDX_W'(n);
            w.last    = (n == total - 1);
            owed.push_back(w);
            n++;
          end
        end
      end
      cells_seen++;
    endfunction

    function void report(string what, logic [CODE_W-1:0] exp_v, logic [CODE_W-1:0] got_v);
      errors++;
      $display("%0t: %s wrong, expected %h actual %h", $time, what, exp_v, got_v);
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] tdata, logic present, logic last);
      nbr_word_t e;
      logic [IDX_W-1:0] got_idx;
      words_seen++;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: word with nothing owed, expected none actual %h", $time, tdata);
        return;
      end
      e = owed.pop_front();
      got_idx = tdata[CODE_W +: IDX_W];
      if (tdata[CODE_W-1:0] !== e.code) report("neighbour_code", e.code, tdata[CODE_W-1:0]);
      if (present !== e.present)        report("present", CODE_W'(e.present), CODE_W'(present));
      if (got_idx !== e.idx)            report("offset_index", CODE_W'(e.idx), CODE_W'(got_idx));
      if (last !== e.last)              report("last", CODE_W'(e.last), CODE_W'(last));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // cell_code [62:0], zero pad [63]
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;  // neighbour_code [62:0], offset_index [67:63], pad
  logic                   out_tuser;  // present
  logic                   out_tlast;

  neighbour_board board;
  bit             steady;      // no idling on either side while set
  int             stall_left;
  int             cycles;
  int             phases_run;

  morton_neighbour_cells DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog, a hung block ends the run here
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long ones
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side back-pressure, changes only on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // every accepted result word goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_word(out_tdata, out_tuser, out_tlast);
  end

  // offer one cell word after a random gap and hold it until accepted
  task automatic send_cell(logic [CODE_W-1:0] code);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - CODE_W){1'b0}}, code};
    do @(posedge clk); while (!in_tready);
    board.predict_run(code);
  endtask

  // sender pauses until every owed word is back, then lets the pipe settle
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.owed.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic write_cells(longint cx, longint cy, longint cz);
    write_reg(CFG_CELLS_X, CFG_W'(cx));
    write_reg(CFG_CELLS_Y, CFG_W'(cy));
    write_reg(CFG_CELLS_Z, CFG_W'(cz));
  endtask

  // cell count for a random phase, small grids most of the time
  function longint pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(1, 12);
    if (r < 65) return $urandom_range(13, 5000);
    if (r < 80) return $urandom_range(1, AXIS_SPAN);
    if (r < 90) return AXIS_SPAN;
    if (r < 95) return (64'd1 << CELLS_W) - 1;
    return 0;
  endfunction

  // coordinate near the interesting spots of one axis
  function longint pick_coord(logic [CELLS_W-1:0] count);
    longint top;
    int     r;
    top = (longint'(count) + 1 > AXIS_MAX) ? AXIS_MAX : longint'(count) + 1;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return (count == 0) ? 0 : ((longint'(count) - 1 > AXIS_MAX) ? AXIS_MAX
                                                                           : longint'(count) - 1);
    if (r < 25) return (longint'(count) > AXIS_MAX) ? AXIS_MAX : longint'(count);
    if (r < 30) return AXIS_MAX;
    return $urandom_range(0, top);
  endfunction

  // mostly in-grid origins, the rest fully random 63 bit codes
  function logic [CODE_W-1:0] pick_cell();
    logic [63:0] raw;
    if ($urandom_range(0, 99) < 15) begin
      raw = {$urandom(), $urandom()};
      return raw[CODE_W-1:0];
    end
    return board.pack_cell(pick_coord(board.cells_x), pick_coord(board.cells_y),
                           pick_coord(board.cells_z));
  endfunction

  initial begin
    logic [CODE_W-1:0] all_ones;
    board = new();
    board.reset_regs();
    all_ones  = '1;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_REACH;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    steady    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: corners, middle, origin outside the grid, unencodable codes
    send_cell(board.pack_cell(0, 0, 0));
    send_cell(board.pack_cell(9, 9, 9));
    send_cell(board.pack_cell(5, 5, 5));
    send_cell(board.pack_cell(10, 3, 7));
    send_cell(board.pack_cell(0, 9, 4));
    send_cell(all_ones);
    send_cell({(CODE_W/3){3'b101}});
    send_cell({(CODE_W/3){3'b010}});
    drain();

    // full 2^21 grid: top coordinate has no encodable +1 neighbour
    write_cells(AXIS_SPAN, AXIS_SPAN, AXIS_SPAN);
    send_cell(all_ones);
    send_cell(board.pack_cell(AXIS_MAX - 1, 0, AXIS_MAX - 1));
    send_cell(board.pack_cell(0, AXIS_MAX, 1));
    drain();

    // zero count on x makes every neighbour absent
    write_reg(CFG_CELLS_X, '0);
    send_cell(board.pack_cell(0, 0, 0));
    send_cell(board.pack_cell(3, 3, 3));
    drain();

    // reach 0 on a single-cell grid
    write_reg(CFG_REACH, CFG_W'(0));
    write_cells(1, 1, 1);
    send_cell(board.pack_cell(0, 0, 0));
    send_cell(board.pack_cell(1, 0, 0));
    send_cell(board.pack_cell(0, 0, 1));
    drain();

    // widest count register value, both reach settings
    write_cells((64'd1 << CELLS_W) - 1, (64'd1 << CELLS_W) - 1, (64'd1 << CELLS_W) - 1);
    send_cell(all_ones);
    drain();
    write_reg(CFG_REACH, CFG_W'(1));
    send_cell(all_ones);
    send_cell(board.pack_cell(AXIS_MAX - 1, AXIS_MAX - 1, 0));
    drain();

    // random phases, each with its own settings
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_REACH, CFG_W'($urandom_range(0, 3) != 0));
      write_cells(pick_count(), pick_count(), pick_count());
      steady = (p == 3);
      for (int i = 0; i < 50; i++) begin
        send_cell(pick_cell());
        // one mid-phase pause until the block is empty
        if (p == 2 && i == 25) drain();
      end
      drain();
      phases_run++;
    end
    steady = 1'b0;

    if (board.owed.size() != 0) begin
      board.errors++;
      $display("%0t: %0d neighbour words never arrived, expected none actual %0d left",
               $time, board.owed.size(), board.owed.size());
    end

    $display("checked %0d neighbour words from %0d origin cells", board.words_seen,
             board.cells_seen);
    $display("directed corner cases plus %0d random phases, %0d errors", phases_run,
             board.errors);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
